@@ hw/rtl/pulse_width_packet_receiver_unit_defines.svh @@
// Assertion macros shared by the pulse width packet receiver RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef PULSE_WIDTH_PACKET_RECEIVER_UNIT_DEFINES_SVH
`define PULSE_WIDTH_PACKET_RECEIVER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PWPR_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pwpr: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PWPR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pwpr: next-cycle check failed");

`endif

@@ hw/rtl/pwpr_pkg.sv @@
// Package of the pulse width packet receiver: sizes, reset values, register
// indexes, shared types and the packet check functions. Depends on nothing.
`default_nettype none

package pwpr_pkg;

    // Packet framing.
    localparam int PREAMBLE_BITS = 10;
    localparam int DATA_BITS     = 8;
    localparam int HISTORY_BITS  = 19;
    localparam int COUNT_BITS    = 16;
    localparam int PACKET_LEN    = PREAMBLE_BITS + DATA_BITS + 1;
    localparam logic [31:0] PREAMBLE_PATTERN = 32'h0000_02AA;
    localparam int BYTE_BITS     = 8;

    // Fixed point formats.
    localparam int LEVEL_BITS   = 18;
    localparam int LWEIGHT_BITS = 17;
    localparam int LEVEL_FRAC   = 16;
    localparam int FRAC_BITS    = 24;
    localparam int WWEIGHT_BITS = 25;
    localparam int LIMIT_BITS   = 16;
    localparam int INIT_BITS    = 16;
    localparam int THR_BITS     = COUNT_BITS + FRAC_BITS;
    localparam int SAMPLE_BITS  = 2;

    localparam logic [LWEIGHT_BITS-1:0] LWEIGHT_ONE = LWEIGHT_BITS'(1 << LEVEL_FRAC);
    localparam logic [WWEIGHT_BITS-1:0] WWEIGHT_ONE = WWEIGHT_BITS'(1 << FRAC_BITS);

    // Configuration port.
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 25;

    localparam logic [CFG_IDX_BITS-1:0] CFG_RISE_THRESHOLD     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FALL_THRESHOLD     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LEVEL_WEIGHT       = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INIT_WIDTH_THRESH  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH_WEIGHT       = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ADAPT_LIMIT        = 3'd5;

    localparam logic [LEVEL_BITS-1:0]    RST_RISE_THRESHOLD = 18'd6554;
    localparam logic [LEVEL_BITS-1:0]    RST_FALL_THRESHOLD = 18'd655;
    localparam logic [LWEIGHT_BITS-1:0]  RST_LEVEL_WEIGHT   = 17'd13107;
    localparam logic [INIT_BITS-1:0]     RST_INIT_WIDTH     = 16'd80;
    localparam logic [WWEIGHT_BITS-1:0]  RST_WIDTH_WEIGHT   = 25'd1678;
    localparam logic [LIMIT_BITS-1:0]    RST_ADAPT_LIMIT    = 16'd1000;

    // Edge queue between front and back.
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [LEVEL_BITS-1:0]   rise_threshold;
        logic [LEVEL_BITS-1:0]   fall_threshold;
        logic [LWEIGHT_BITS-1:0] level_weight;
        logic [WWEIGHT_BITS-1:0] width_weight;
        logic [LIMIT_BITS-1:0]   adapt_limit;
    } t_cfg;

    // Falling edge event: the measured pulse width.
    typedef struct packed {
        logic                  vld;
        logic [COUNT_BITS-1:0] width;
    } t_evt;

    // Threshold reload caused by a write of the initial width threshold.
    typedef struct packed {
        logic                 load;
        logic [INIT_BITS-1:0] value;
    } t_thr_load;

    typedef enum logic [0:0] {
        BK_IDLE,
        BK_ADAPT
    } t_back_state;

    // Oldest preamble bit sits at the top of the packet window.
    function automatic logic preamble_hit(input logic [HISTORY_BITS-1:0] hist);
        logic hit;
        hit = (HISTORY_BITS >= PACKET_LEN);
        for (int k = 0; k < PREAMBLE_BITS; k++) begin
            if (hist[PACKET_LEN-1-k] != PREAMBLE_PATTERN[k]) begin
                hit = 1'b0;
            end
        end
        return hit;
    endfunction

    // Even parity: XOR of the data bits equals the last bit received.
    function automatic logic parity_good(input logic [HISTORY_BITS-1:0] hist);
        return (^hist[DATA_BITS:1]) == hist[0];
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pwpr_front.sv @@
// Front end: level filter and hysteresis edge detector with width counter.
// Depends on pwpr_pkg. Pushes one event per falling edge into the edge queue.
`default_nettype none

module pwpr_front (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic [pwpr_pkg::SAMPLE_BITS-1:0]     i_contention_sample,
    input  wire pwpr_pkg::t_cfg                       i_cfg,
    input  wire logic                                 i_queue_afull,
    output pwpr_pkg::t_evt                            o_evt
);

    localparam int LVL_W = pwpr_pkg::LEVEL_BITS;
    localparam int ACC_W = pwpr_pkg::LEVEL_BITS + pwpr_pkg::LWEIGHT_BITS + 1;
    localparam int FRAC  = pwpr_pkg::LEVEL_FRAC;
    localparam int CNT_W = pwpr_pkg::COUNT_BITS;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [ACC_W-1:0] HALF    = ACC_W'(1 << (FRAC - 1));

    logic                                 accept;
    logic [pwpr_pkg::LWEIGHT_BITS-1:0]    w_sat;
    logic [pwpr_pkg::LWEIGHT_BITS-1:0]    w_inv;
    logic [ACC_W-1:0]                     acc;
    logic [LVL_W-1:0]                     r_level, n_level;
    logic                                 r_s1_vld;
    logic                                 r_high, n_high;
    logic [CNT_W-1:0]                     r_count, n_count;
    logic [CNT_W-1:0]                     count_base;
    logic                                 fall_edge;

    assign o_stall = i_queue_afull;
    assign accept  = i_valid && !o_stall;

    // Stage 1: first order low-pass filter of the sample.
    always_comb begin
        w_sat   = (i_cfg.level_weight > pwpr_pkg::LWEIGHT_ONE) ?
                  pwpr_pkg::LWEIGHT_ONE : i_cfg.level_weight;
        w_inv   = pwpr_pkg::LWEIGHT_ONE - w_sat;
        acc     = ACC_W'(r_level) * ACC_W'(w_inv)
                + ((ACC_W'(i_contention_sample) * ACC_W'(w_sat)) << FRAC)
                + HALF;
        n_level = acc[LVL_W+FRAC-1:FRAC];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level  <= '0;
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= accept;
            if (accept) begin
                r_level <= n_level;
            end
        end
    end

    // Stage 2: hysteresis and pulse width counter.
    always_comb begin
        n_high     = r_high;
        n_count    = r_count;
        count_base = r_count;
        fall_edge  = 1'b0;
        if (r_s1_vld) begin
            if (!r_high) begin
                if (r_level > i_cfg.rise_threshold) begin
                    count_base = '0;
                    n_high     = 1'b1;
                end
            end else if (r_level < i_cfg.fall_threshold) begin
                fall_edge  = 1'b1;
                count_base = '0;
                n_high     = 1'b0;
            end
            n_count = (count_base != CNT_MAX) ? count_base + 1'b1 : count_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high  <= 1'b0;
            r_count <= '0;
        end else begin
            r_high  <= n_high;
            r_count <= n_count;
        end
    end

    // The width is the count before this tick's increment.
    assign o_evt.vld   = fall_edge;
    assign o_evt.width = r_count;

endmodule

`default_nettype wire

@@ hw/rtl/pwpr_fifo.sv @@
// Short queue of falling edge events between front end and back end.
// Depends on pwpr_pkg and the assertion macro header.
`default_nettype none
`include "pulse_width_packet_receiver_unit_defines.svh"

module pwpr_fifo (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire pwpr_pkg::t_evt                     i_push,
    output logic                                    o_afull,
    output logic                                    o_valid,
    output logic [pwpr_pkg::COUNT_BITS-1:0]         o_width,
    input  wire logic                               i_pop
);

    localparam int DEPTH = pwpr_pkg::FIFO_DEPTH;
    localparam int PTR_W = pwpr_pkg::FIFO_PTR_BITS;
    localparam int CNT_W = PTR_W + 1;

    logic [pwpr_pkg::COUNT_BITS-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]                r_wr_ptr;
    logic [PTR_W-1:0]                r_rd_ptr;
    logic [CNT_W-1:0]                r_count;

    always_ff @(posedge i_clk) begin
        if (i_push.vld) begin
            r_mem[r_wr_ptr] <= i_push.width;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.vld) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push.vld && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push.vld && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Room is held back for the sample still inside the front end.
    assign o_afull = (r_count >= CNT_W'(DEPTH - 1));
    assign o_valid = (r_count != '0);
    assign o_width = r_mem[r_rd_ptr];

    `PWPR_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, r_count == CNT_W'(DEPTH), !i_push.vld)
    `PWPR_ASSERT_IMPL(a_no_underflow, i_clk, i_rst_n, r_count == '0, !i_pop)

endmodule

`default_nettype wire

@@ hw/rtl/pwpr_back.sv @@
// Back end: bit decision, history shift, packet check, adaptive threshold
// and the output register. Depends on pwpr_pkg and the assertion macros.
`default_nettype none
`include "pulse_width_packet_receiver_unit_defines.svh"

module pwpr_back (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire pwpr_pkg::t_cfg                     i_cfg,
    input  wire pwpr_pkg::t_thr_load                i_thr_load,
    input  wire logic                               i_evt_valid,
    input  wire logic [pwpr_pkg::COUNT_BITS-1:0]    i_evt_width,
    output logic                                    o_pop,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic [pwpr_pkg::BYTE_BITS-1:0]          o_packet_byte
);

    localparam int THR_W  = pwpr_pkg::THR_BITS;
    localparam int FRAC   = pwpr_pkg::FRAC_BITS;
    localparam int CNT_W  = pwpr_pkg::COUNT_BITS;
    localparam int WW_W   = pwpr_pkg::WWEIGHT_BITS;
    localparam int HIST_W = pwpr_pkg::HISTORY_BITS;
    localparam int HI_W   = CNT_W + WW_W;
    localparam int LO_W   = FRAC + WW_W;
    localparam int LIM_W  = (CNT_W > pwpr_pkg::LIMIT_BITS) ? CNT_W : pwpr_pkg::LIMIT_BITS;
    localparam int PKT_CLR = (HIST_W > pwpr_pkg::PACKET_LEN) ?
                             (HIST_W - pwpr_pkg::PACKET_LEN) : 0;
    localparam logic [HIST_W-1:0] PKT_MASK = {HIST_W{1'b1}} >> PKT_CLR;
    localparam logic [LO_W:0]     LO_HALF  = (LO_W + 1)'(1 << (FRAC - 1));

    pwpr_pkg::t_back_state r_state, n_state;

    logic [THR_W-1:0]   r_thr;
    logic [HIST_W-1:0]  r_hist;
    logic               r_up;
    logic               r_adapt;
    logic [HI_W-1:0]    r_p_hi;
    logic [LO_W-1:0]    r_p_lo;
    logic               r_out_vld;
    logic [pwpr_pkg::BYTE_BITS-1:0] r_out_byte;

    logic               out_free;
    logic               thr_upd;
    logic [THR_W-1:0]   target;
    logic               bit_one;
    logic [HIST_W-1:0]  hist_sh;
    logic               hit;
    logic               emit;
    logic               up;
    logic [THR_W-1:0]   mag;
    logic [WW_W-1:0]    w_sat;
    logic [LO_W:0]      lo_rnd;
    logic [THR_W-1:0]   delta;

    assign out_free = !r_out_vld || !i_stall;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            pwpr_pkg::BK_IDLE: begin
                if (i_evt_valid && out_free) begin
                    n_state = pwpr_pkg::BK_ADAPT;
                end
            end
            pwpr_pkg::BK_ADAPT: begin
                n_state = pwpr_pkg::BK_IDLE;
            end
            default: begin
                n_state = pwpr_pkg::BK_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb begin
        o_pop   = 1'b0;
        thr_upd = 1'b0;
        case (r_state)
            pwpr_pkg::BK_IDLE: begin
                o_pop = i_evt_valid && out_free;
            end
            pwpr_pkg::BK_ADAPT: begin
                thr_upd = r_adapt;
            end
            default: begin
                o_pop   = 1'b0;
                thr_upd = 1'b0;
            end
        endcase
    end

    // Decision, history and the two partial products of the threshold step.
    always_comb begin
        target  = {i_evt_width, {FRAC{1'b0}}};
        bit_one = (target < r_thr);
        hist_sh = {r_hist[HIST_W-2:0], bit_one};
        hit     = pwpr_pkg::preamble_hit(hist_sh);
        emit    = hit && pwpr_pkg::parity_good(hist_sh);
        up      = (target >= r_thr);
        mag     = up ? (target - r_thr) : (r_thr - target);
        w_sat   = (i_cfg.width_weight > pwpr_pkg::WWEIGHT_ONE) ?
                  pwpr_pkg::WWEIGHT_ONE : i_cfg.width_weight;
        lo_rnd  = (LO_W + 1)'(r_p_lo) + LO_HALF;
        delta   = THR_W'(r_p_hi) + THR_W'(lo_rnd[LO_W:FRAC]);
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_up    <= up;
            r_adapt <= (LIM_W'(i_evt_width) < LIM_W'(i_cfg.adapt_limit));
            r_p_hi  <= HI_W'(mag[THR_W-1:FRAC]) * HI_W'(w_sat);
            r_p_lo  <= LO_W'(mag[FRAC-1:0]) * LO_W'(w_sat);
        end
        if (o_pop && emit) begin
            r_out_byte <= pwpr_pkg::BYTE_BITS'(hist_sh[pwpr_pkg::DATA_BITS:1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pwpr_pkg::BK_IDLE;
            r_thr     <= {pwpr_pkg::RST_INIT_WIDTH, {FRAC{1'b0}}};
            r_hist    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_thr_load.load) begin
                r_thr <= {i_thr_load.value, {FRAC{1'b0}}};
            end else if (thr_upd) begin
                r_thr <= r_up ? (r_thr + delta) : (r_thr - delta);
            end
            if (o_pop) begin
                r_hist <= hit ? (hist_sh & ~PKT_MASK) : hist_sh;
            end
            if (o_pop && emit) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_valid       = r_out_vld;
    assign o_packet_byte = r_out_byte;

    `PWPR_ASSERT_NEXT(a_adapt_one_cycle, i_clk, i_rst_n, r_state == pwpr_pkg::BK_ADAPT, r_state == pwpr_pkg::BK_IDLE)
    `PWPR_ASSERT_IMPL(a_pop_needs_room, i_clk, i_rst_n, o_pop, !r_out_vld || !i_stall)
    `PWPR_ASSERT_IMPL(a_load_when_idle, i_clk, i_rst_n, i_thr_load.load, r_state == pwpr_pkg::BK_IDLE)

endmodule

`default_nettype wire

@@ hw/rtl/pulse_width_packet_receiver_unit.sv @@
// Top level of the pulse width packet receiver: configuration registers and
// the front end, edge queue and back end. Depends on pwpr_pkg, pwpr_front,
// pwpr_fifo and pwpr_back.
//
//   Channel   Direction  Handshake               Payload
//   sample    in         i_valid / o_stall       i_contention_sample[1:0]
//   byte      out        o_valid / i_stall       o_packet_byte[7:0]
//   config    in         i_cfg_valid / o_cfg_ready  i_cfg_index[2:0], i_cfg_data[24:0]
//
// One sample beat is taken every cycle while o_stall is low. A sample passes the
// level filter register, then the edge detector; a falling edge becomes a queue
// entry. The back end pops each queued edge in its idle state and runs the
// threshold update loop (a multiply stage, then the add) in its adapt state; the
// byte register loads as the edge that completes its packet is popped. Pulses
// span at least two samples, so with no byte stall edges never arrive faster than
// the back end drains them. Reset is synchronous and active low and loads every
// configuration register with its documented default. A stall on the byte channel
// holds the output register; the back end then stops popping, the queue fills and
// o_stall rises once one entry of room is left for the sample still in the front end.
`default_nettype none

module pulse_width_packet_receiver_unit (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic [pwpr_pkg::SAMPLE_BITS-1:0]      i_contention_sample,
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic [pwpr_pkg::BYTE_BITS-1:0]             o_packet_byte,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [pwpr_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  wire logic [pwpr_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);

    logic                                  cfg_wr;
    pwpr_pkg::t_cfg                        r_cfg;
    pwpr_pkg::t_thr_load                   thr_load;
    pwpr_pkg::t_evt                        evt;
    logic                                  queue_afull;
    logic                                  queue_valid;
    logic [pwpr_pkg::COUNT_BITS-1:0]       queue_width;
    logic                                  queue_pop;

    // The register file always takes a write beat.
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rise_threshold <= pwpr_pkg::RST_RISE_THRESHOLD;
            r_cfg.fall_threshold <= pwpr_pkg::RST_FALL_THRESHOLD;
            r_cfg.level_weight   <= pwpr_pkg::RST_LEVEL_WEIGHT;
            r_cfg.width_weight   <= pwpr_pkg::RST_WIDTH_WEIGHT;
            r_cfg.adapt_limit    <= pwpr_pkg::RST_ADAPT_LIMIT;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                pwpr_pkg::CFG_RISE_THRESHOLD: begin
                    r_cfg.rise_threshold <= i_cfg_data[pwpr_pkg::LEVEL_BITS-1:0];
                end
                pwpr_pkg::CFG_FALL_THRESHOLD: begin
                    r_cfg.fall_threshold <= i_cfg_data[pwpr_pkg::LEVEL_BITS-1:0];
                end
                pwpr_pkg::CFG_LEVEL_WEIGHT: begin
                    r_cfg.level_weight <= i_cfg_data[pwpr_pkg::LWEIGHT_BITS-1:0];
                end
                pwpr_pkg::CFG_WIDTH_WEIGHT: begin
                    r_cfg.width_weight <= i_cfg_data[pwpr_pkg::WWEIGHT_BITS-1:0];
                end
                pwpr_pkg::CFG_ADAPT_LIMIT: begin
                    r_cfg.adapt_limit <= i_cfg_data[pwpr_pkg::LIMIT_BITS-1:0];
                end
                default: begin
                    // The initial width threshold lives only in the back end's
                    // threshold register; other indexes are ignored.
                end
            endcase
        end
    end

    // Writing the initial width threshold reloads the adaptive threshold.
    assign thr_load.load  = cfg_wr && (i_cfg_index == pwpr_pkg::CFG_INIT_WIDTH_THRESH);
    assign thr_load.value = i_cfg_data[pwpr_pkg::INIT_BITS-1:0];

    pwpr_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_contention_sample (i_contention_sample),
        .i_cfg               (r_cfg),
        .i_queue_afull       (queue_afull),
        .o_evt               (evt)
    );

    pwpr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (evt),
        .o_afull (queue_afull),
        .o_valid (queue_valid),
        .o_width (queue_width),
        .i_pop   (queue_pop)
    );

    pwpr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_thr_load    (thr_load),
        .i_evt_valid   (queue_valid),
        .i_evt_width   (queue_width),
        .o_pop         (queue_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_packet_byte (o_packet_byte)
    );

endmodule

`default_nettype wire

@@ tb/sv/pwpr_byte_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard of the pulse width packet receiver: predicts the demodulator per
// accepted sample beat and compares every byte beat. Depends on pwpr_pkg.
module pwpr_byte_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_sample_valid,
    input  logic                                i_sample_stall,
    input  logic [pwpr_pkg::SAMPLE_BITS-1:0]    i_sample,
    input  logic                                i_byte_valid,
    input  logic                                i_byte_stall,
    input  logic [pwpr_pkg::BYTE_BITS-1:0]      i_byte,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [pwpr_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [pwpr_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import pwpr_pkg::*;

    localparam logic [63:0] FRAC_MASK  = (64'd1 << FRAC_BITS) - 64'd1;
    localparam logic [63:0] FRAC_HALF  = 64'd1 << (FRAC_BITS - 1);
    localparam logic [63:0] LEVEL_HALF = 64'd1 << (LEVEL_FRAC - 1);

    // Register copies.
    logic [LEVEL_BITS-1:0]   rise_thr;
    logic [LEVEL_BITS-1:0]   fall_thr;
    logic [LWEIGHT_BITS-1:0] level_wt;
    logic [INIT_BITS-1:0]    init_width;
    logic [WWEIGHT_BITS-1:0] width_wt;
    logic [LIMIT_BITS-1:0]   adapt_lim;

    // Demodulator state.
    logic [LEVEL_BITS-1:0]   level;
    logic                    pulse_on;
    logic [COUNT_BITS-1:0]   ticks;
    logic [THR_BITS-1:0]     width_thr;
    logic [HISTORY_BITS-1:0] history;

    logic [BYTE_BITS-1:0]    expected_bytes[$];
    int                      fails = 0;

    task automatic clear_model();
        rise_thr   = RST_RISE_THRESHOLD;
        fall_thr   = RST_FALL_THRESHOLD;
        level_wt   = RST_LEVEL_WEIGHT;
        init_width = RST_INIT_WIDTH;
        width_wt   = RST_WIDTH_WEIGHT;
        adapt_lim  = RST_ADAPT_LIMIT;
        level      = '0;
        pulse_on   = 1'b0;
        ticks      = '0;
        width_thr  = THR_BITS'(RST_INIT_WIDTH) << FRAC_BITS;
        history    = '0;
        expected_bytes.delete();
    endtask

    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] value);
        case (idx)
            CFG_RISE_THRESHOLD: rise_thr = value[LEVEL_BITS-1:0];
            CFG_FALL_THRESHOLD: fall_thr = value[LEVEL_BITS-1:0];
            CFG_LEVEL_WEIGHT:   level_wt = value[LWEIGHT_BITS-1:0];
            CFG_INIT_WIDTH_THRESH: begin
                init_width = value[INIT_BITS-1:0];
                width_thr  = THR_BITS'(init_width) << FRAC_BITS;
            end
            CFG_WIDTH_WEIGHT:   width_wt  = value[WWEIGHT_BITS-1:0];
            CFG_ADAPT_LIMIT:    adapt_lim = value[LIMIT_BITS-1:0];
            default: ;
        endcase
    endtask

    // Slow first-order filter of the width threshold, rounded half away from zero.
    task automatic track_threshold(input logic [COUNT_BITS-1:0] width);
        logic [63:0] wt;
        logic [63:0] target;
        logic [63:0] cur;
        logic [63:0] mag;
        logic [63:0] delta;
        wt     = (width_wt > WWEIGHT_ONE) ? 64'(WWEIGHT_ONE) : 64'(width_wt);
        target = 64'(width) << FRAC_BITS;
        cur    = 64'(width_thr);
        mag    = (target >= cur) ? target - cur : cur - target;
        delta  = (mag >> FRAC_BITS) * wt + (((mag & FRAC_MASK) * wt + FRAC_HALF) >> FRAC_BITS);
        width_thr = THR_BITS'((target >= cur) ? cur + delta : cur - delta);
    endtask

    task automatic demodulate_sample(input logic [SAMPLE_BITS-1:0] sample);
        logic [63:0]           wt;
        logic [63:0]           acc;
        logic [COUNT_BITS-1:0] width;
        logic                  bit_in;
        logic                  hit;
        logic [DATA_BITS-1:0]  payload;
        int                    k;
        wt    = (level_wt > LWEIGHT_ONE) ? 64'(LWEIGHT_ONE) : 64'(level_wt);
        acc   = 64'(level) * (64'(LWEIGHT_ONE) - wt) + (64'(sample) << LEVEL_FRAC) * wt
                + LEVEL_HALF;
        level = acc[LEVEL_FRAC +: LEVEL_BITS];
        if (!pulse_on) begin
            if (level > rise_thr) begin
                ticks    = '0;
                pulse_on = 1'b1;
            end
        end else if (level < fall_thr) begin
            width   = ticks;
            bit_in  = (64'(width) << FRAC_BITS) < 64'(width_thr);
            history = {history[HISTORY_BITS-2:0], bit_in};
            hit     = (HISTORY_BITS >= PACKET_LEN);
            for (k = 0; k < PREAMBLE_BITS; k++) begin
                if (history[PACKET_LEN-1-k] != PREAMBLE_PATTERN[k]) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                payload = history[DATA_BITS:1];
                if ((^payload) == history[0]) begin
                    expected_bytes.push_back(BYTE_BITS'(payload));
                end
                for (k = 0; k < PACKET_LEN; k++) begin
                    history[k] = 1'b0;
                end
            end
            if (width < adapt_lim) begin
                track_threshold(width);
            end
            ticks    = '0;
            pulse_on = 1'b0;
        end
        if (ticks != '1) begin
            ticks = ticks + 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_model();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                write_register(i_cfg_index, i_cfg_data);
            end
            if (i_byte_valid && !i_byte_stall) begin
                if (expected_bytes.size() == 0) begin
                    $error("packet_byte: unexpected beat, expected none, actual 0x%02h", i_byte);
                    fails++;
                end else if (expected_bytes[0] !== i_byte) begin
                    $error("packet_byte: expected 0x%02h, actual 0x%02h",
                           expected_bytes[0], i_byte);
                    fails++;
                    void'(expected_bytes.pop_front());
                end else begin
                    void'(expected_bytes.pop_front());
                end
            end
            if (i_sample_valid && !i_sample_stall) begin
                demodulate_sample(i_sample);
            end
        end
        o_pending    <= expected_bytes.size();
        o_fail_count <= fails;
    end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Top of the pulse width packet receiver testbench: clock, reset, sample and
// register stimulus, watchdog and verdict. Depends on pwpr_pkg, the block and
// pwpr_byte_checker.
module testbench;
    import pwpr_pkg::*;

    // Cycles allowed for the block to drain after the last expected byte.
    localparam int SETTLE_CYCLES  = 32;
    // Cycles without any accepted beat before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 4000;
    // A pulse long enough to saturate the width counter.
    localparam int LONG_PULSE     = 70000;
    localparam int SAMPLE_MAX     = (1 << SAMPLE_BITS) - 1;
    localparam int PHASES         = 9;

    // Indexes that map to no register; writes to them must be ignored.
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HI = 3'd7;

    localparam logic [SAMPLE_BITS-1:0] DIRECTED_SAMPLES [24] = '{
        2'd0, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd1, 2'd2,
        2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd0, 2'd0, 2'd0,
        2'd3, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0
    };

    typedef enum int {
        PHASE_SLOW,
        PHASE_FAST,
        PHASE_EXTREME
    } t_phase_kind;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic [SAMPLE_BITS-1:0]   i_contention_sample = '0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic [BYTE_BITS-1:0]     o_packet_byte;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    int fail_count;
    int pending;
    int idle_cycles = 0;

    // Percentages of cycles in which the sample source and the byte sink idle.
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    // Pulse shape of the current phase, in samples.
    int short_lo = 1;
    int short_hi = 2;
    int long_lo  = 4;
    int long_hi  = 8;
    int gap_lo   = 1;
    int gap_hi   = 2;
    int high_min = 1;

    always #5 i_clk = ~i_clk;

    pulse_width_packet_receiver_unit u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_contention_sample (i_contention_sample),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_packet_byte       (o_packet_byte),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    pwpr_byte_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_valid),
        .i_sample_stall (o_stall),
        .i_sample       (i_contention_sample),
        .i_byte_valid   (o_valid),
        .i_byte_stall   (i_stall),
        .i_byte         (o_packet_byte),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // The byte sink stalls at random with the rate of the current phase.
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // The watchdog restarts on any accepted beat of any channel. Sample beats
    // keep flowing while stimulus runs, so only a hung block trips it.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("pulse_width_packet_receiver_unit test failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // One sample beat. Idle cycles are drawn before the beat is offered, so
    // the valid line never reacts to the stall and a stalled beat holds still.
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] value);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid             <= 1'b1;
        i_contention_sample <= value;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_noise(input int count);
        repeat (count) send_sample($urandom_range(SAMPLE_MAX));
    endtask

    // A pulse is a run of nonzero samples followed by a run of zeros.
    task automatic emit_pulse(input int high_len, input int low_len);
        repeat (high_len) send_sample($urandom_range(high_min, SAMPLE_MAX));
        repeat (low_len) send_sample('0);
    endtask

    // Preamble, data MSB first and even parity, oldest bit at the top of the
    // frame. One packet in six carries a flipped parity bit and must be dropped.
    task automatic send_packet();
        logic [PACKET_LEN-1:0] frame;
        logic [DATA_BITS-1:0]  payload;
        int                    k;
        payload = DATA_BITS'($urandom);
        for (k = 0; k < PREAMBLE_BITS; k++) begin
            frame[PACKET_LEN-1-k] = PREAMBLE_PATTERN[k];
        end
        frame[DATA_BITS:1] = payload;
        frame[0] = (^payload) ^ ($urandom_range(5) == 0);
        for (k = PACKET_LEN - 1; k >= 0; k--) begin
            if (frame[k]) begin
                emit_pulse($urandom_range(short_lo, short_hi), $urandom_range(gap_lo, gap_hi));
            end else begin
                emit_pulse($urandom_range(long_lo, long_hi), $urandom_range(gap_lo, gap_hi));
            end
        end
    endtask

    // Register beats go back to back; the caller drops the valid afterwards.
    // Bits above the register width are random, the block must ignore them.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] value,
                             input int width);
        logic [63:0] mask;
        mask        = (64'd1 << width) - 64'd1;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_BITS'((64'(value) & mask) | ((64'($urandom)) << width));
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic program_regs(input logic [31:0] rise, input logic [31:0] fall,
                                input logic [31:0] lweight, input logic [31:0] init_width,
                                input logic [31:0] wweight, input logic [31:0] limit,
                                input logic with_spare);
        write_reg(CFG_RISE_THRESHOLD, rise, LEVEL_BITS);
        write_reg(CFG_FALL_THRESHOLD, fall, LEVEL_BITS);
        write_reg(CFG_LEVEL_WEIGHT, lweight, LWEIGHT_BITS);
        write_reg(CFG_INIT_WIDTH_THRESH, init_width, INIT_BITS);
        write_reg(CFG_WIDTH_WEIGHT, wweight, WWEIGHT_BITS);
        write_reg(CFG_ADAPT_LIMIT, limit, LIMIT_BITS);
        if (with_spare) begin
            write_reg(CFG_SPARE_LO, $urandom, CFG_DATA_BITS);
            write_reg(CFG_SPARE_HI, $urandom, CFG_DATA_BITS);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Wait until every predicted byte has arrived, then give the back end time
    // to finish edges that produce no byte, so that a register write finds the
    // block idle.
    task automatic settle_block();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int          p;
        int          n;
        int          thr;
        t_phase_kind kind;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed samples at the reset configuration: both extremes of the
        // sample and a short burst that must not produce any byte.
        tx_idle_pct = 10;
        rx_idle_pct = 48;
        foreach (DIRECTED_SAMPLES[n]) begin
            send_sample(DIRECTED_SAMPLES[n]);
        end

        for (p = 0; p < PHASES; p++) begin
            settle_block();
            // Idling order: sender light and sink heavy, then the reverse,
            // then a full-rate stretch with no idling on either side.
            case (p / 3)
                0: begin
                    tx_idle_pct = 10;
                    rx_idle_pct = 48;
                end
                1: begin
                    tx_idle_pct = 48;
                    rx_idle_pct = 10;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            kind = t_phase_kind'(p % 3);

            case (kind)
                PHASE_SLOW: begin
                    // Default filter: a pulse is stretched by roughly 26 ticks
                    // of decay, so short pulses land far below the 80 tick
                    // threshold and long ones far above it.
                    program_regs(RST_RISE_THRESHOLD, RST_FALL_THRESHOLD, RST_LEVEL_WEIGHT,
                                 RST_INIT_WIDTH, RST_WIDTH_WEIGHT, RST_ADAPT_LIMIT, 1'b0);
                    short_lo = 4;
                    short_hi = 12;
                    long_lo  = 70;
                    long_hi  = 110;
                    gap_lo   = 35;
                    gap_hi   = 45;
                    high_min = 2;
                    repeat (3) begin
                        send_packet();
                        send_noise($urandom_range(30));
                        emit_pulse(0, 40);
                    end
                end
                PHASE_FAST: begin
                    // A level weight of one or more makes the level follow the
                    // sample at once, so the width equals the run of nonzero
                    // samples and packets take a few hundred beats.
                    thr = $urandom_range(6, 24);
                    program_regs($urandom_range(65535), $urandom_range(1, 65536),
                                 $urandom_range(65536, 131071), thr, $urandom_range(4000),
                                 $urandom_range(65535), 1'b0);
                    short_lo = 1;
                    short_hi = thr / 2;
                    long_lo  = thr + 2;
                    long_hi  = 2 * thr + 2;
                    gap_lo   = 1;
                    gap_hi   = 4;
                    high_min = 1;
                    repeat (12) begin
                        if ($urandom_range(2) == 0) begin
                            send_noise($urandom_range(1, 12));
                            emit_pulse(0, 4);
                        end
                        send_packet();
                    end
                end
                default: begin
                    short_lo = 1;
                    short_hi = 4;
                    long_lo  = 10;
                    long_hi  = 20;
                    gap_lo   = 1;
                    gap_hi   = 3;
                    high_min = 1;
                    case (p / 3)
                        0: begin
                            // Both weights above one act as one: the threshold
                            // jumps to every width below the limit.
                            program_regs(0, 65536, 131071, $urandom_range(65535),
                                         33554431, 65535, 1'b0);
                            send_noise(200);
                            repeat (4) send_packet();
                            send_noise(100);
                        end
                        1: begin
                            // Unreachable rise threshold and a frozen level:
                            // no edge and no byte may ever appear.
                            program_regs(262143, 0, 0, 0, 0, 0, 1'b0);
                            send_noise(200);
                        end
                        default: begin
                            // Widest threshold and a counter driven into
                            // saturation; spare indexes are written as well.
                            program_regs(65535, 65536, 65536, 65535, 0, 65535, 1'b1);
                            send_noise(100);
                            emit_pulse(LONG_PULSE, 3);
                            send_noise(100);
                            repeat (2) send_packet();
                        end
                    endcase
                end
            endcase
        end

        settle_block();
        if (fail_count == 0) begin
            $display("pulse_width_packet_receiver_unit test passed");
        end else begin
            $display("pulse_width_packet_receiver_unit test failed");
        end
        $finish;
    end

endmodule
